>>> hw/rtl/nmtd_pkg.sv
// Shared widths, stage counts and the per-lane pipeline record for the normal-map texel decoder.
package nmtd_pkg;

  localparam int CodeW      = 8;
  localparam int NumCh      = 3;
  localparam int SqW        = 16;
  localparam int SumW       = 18;
  localparam int FracBits   = 14;
  localparam int QW         = FracBits + 1;
  localparam int UnitW      = 16;
  localparam int ResW       = 50;
  localparam int TShift     = 2 * (FracBits + 1);
  localparam int RootSteps  = QW;
  localparam int PrepStages = 2;
  localparam int NumStages  = PrepStages + RootSteps + 1;

  // One component on its way through the root stages.
  // dif holds 2^30*a^2 - (2q-1)^2*S and err holds (2q-1)*S.
  typedef struct packed {
    logic                   neg;
    logic [SumW-1:0]        sum;
    logic signed [ResW-1:0] dif;
    logic signed [ResW-1:0] err;
    logic [QW-1:0]          q;
  } lane_t;

endpackage

>>> hw/rtl/nmtd_prep.sv
// Front stages: decode channel codes, square them, and seed the root search for each lane.
module nmtd_prep (
  input  logic                                            clk,
  input  logic [nmtd_pkg::PrepStages-1:0]                 en,
  input  logic [nmtd_pkg::NumCh-1:0][nmtd_pkg::CodeW-1:0] code,
  output nmtd_pkg::lane_t [nmtd_pkg::NumCh-1:0]           lane
);
  import nmtd_pkg::*;

  logic [CodeW-1:0]            mag_c [NumCh];
  logic [NumCh-1:0][SqW-1:0]   sq_c;
  logic [NumCh-1:0]            neg_a;
  logic [NumCh-1:0][SqW-1:0]   sq_a;
  logic [SumW-1:0]             sum_c;

  // The value 2c-255 is always odd; its magnitude is the low code bits,
  // inverted when the code sits in the lower half, with a one appended.
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      mag_c[c] = {(code[c][CodeW-1] ? code[c][CodeW-2:0] : ~code[c][CodeW-2:0]), 1'b1};
      sq_c[c]  = SqW'(mag_c[c]) * SqW'(mag_c[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < NumCh; c++) begin
        neg_a[c] <= !code[c][CodeW-1];
        sq_a[c]  <= sq_c[c];
      end
    end
  end

  assign sum_c = SumW'(sq_a[0]) + SumW'(sq_a[1]) + SumW'(sq_a[2]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < NumCh; c++) begin
        lane[c].neg <= neg_a[c];
        lane[c].sum <= sum_c;
        lane[c].dif <= (ResW'(sq_a[c]) << TShift) - ResW'(sum_c);
        lane[c].err <= ResW'(0) - ResW'(sum_c);
        lane[c].q   <= '0;
      end
    end
  end

endmodule

>>> hw/rtl/nmtd_root_pipe.sv
// Bit-by-bit search for the rounded unit component of one lane, one result bit per stage.
module nmtd_root_pipe (
  input  logic                           clk,
  input  logic [nmtd_pkg::RootSteps-1:0] en,
  input  nmtd_pkg::lane_t                lane_in,
  output nmtd_pkg::lane_t                lane_out
);
  import nmtd_pkg::*;

  lane_t st [RootSteps+1];

  assign st[0]    = lane_in;
  assign lane_out = st[RootSteps];

  // Trying bit b on top of q moves (2q-1) to (2q-1+2b), so the square grows by
  // 4b(2q-1) + 4b^2; both terms are shifts of err and sum.
  for (genvar j = 0; j < RootSteps; j++) begin : g_step
    localparam int Lb = RootSteps - 1 - j;
    logic signed [ResW-1:0] sum_ext;
    logic signed [ResW-1:0] cand;
    logic                   take;
    lane_t                  nxt;

    always_comb begin
      sum_ext = {{(ResW-SumW){1'b0}}, st[j].sum};
      cand    = st[j].dif - (st[j].err <<< (2 + Lb)) - (sum_ext <<< (2 * Lb + 2));
      // Once the top bit is set the result is exactly one, nothing can be added.
      take    = !cand[ResW-1] && ((j == 0) || !st[j].q[QW-1]);
      nxt     = st[j];
      if (take) begin
        nxt.dif = cand;
        nxt.err = st[j].err + (sum_ext <<< (Lb + 1));
        nxt.q   = st[j].q | (QW'(1) << Lb);
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j+1] <= nxt;
      end
    end
  end

endmodule

>>> hw/rtl/normal_map_texel_decode_core.sv
// Normal-map texel decoder top level: byte codes in, unit normal in signed Q1.14 out.
// An accepted input beat runs on to its output beat through two front stages,
// fifteen root stages (one result bit each, three lanes side by side) and the output register.
// One beat per cycle when not stalled; every stage holds its own valid bit and fills bubbles.
// Reset (rst, synchronous, active high) clears all valid bits; the data registers keep their value.
module normal_map_texel_decode_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_code [7:0], green_code [15:8], blue_code [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // unit_x [15:0], unit_y [31:16], unit_z [47:32]
);
  import nmtd_pkg::*;

  localparam int Last = NumStages - 1;

  logic [NumStages-1:0]              vld;
  logic [NumStages-1:0]              en;
  logic [NumCh-1:0][CodeW-1:0]       code;
  lane_t [NumCh-1:0]                 seed;
  lane_t                             done [NumCh];
  logic [NumCh-1:0][UnitW-1:0]       unit;

  // A stage loads when it is empty or when the stage after it moves on, so a
  // stalled output only blocks as far back as the pipeline is full.
  always_comb begin
    en[Last] = !vld[Last] || m_tready;
    for (int i = Last - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign code     = s_tdata;

  // Channel decode, squares, the shared sum of squares and the search seed.
  nmtd_prep u_prep (
    .clk  (clk),
    .en   (en[PrepStages-1:0]),
    .code (code),
    .lane (seed)
  );

  // One root search per component; all three see the same sum of squares.
  for (genvar c = 0; c < NumCh; c++) begin : g_lane
    nmtd_root_pipe u_root (
      .clk      (clk),
      .en       (en[PrepStages +: RootSteps]),
      .lane_in  (seed[c]),
      .lane_out (done[c])
    );
  end

  // Output register: restore the sign of each component.
  always_ff @(posedge clk) begin
    if (en[Last]) begin
      for (int c = 0; c < NumCh; c++) begin
        unit[c] <= done[c].neg ? (UnitW'(0) - UnitW'(done[c].q)) : UnitW'(done[c].q);
      end
    end
  end

  assign m_tvalid = vld[Last];
  assign m_tdata  = unit;

endmodule

>>> hw/rtl/nmtd_checker.sv
// Port-level checks for the normal-map texel decoder, bound to the top level.
module nmtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import nmtd_pkg::*;

  localparam int signed UnitMax = 1 << FracBits;

  logic signed [UnitW-1:0] ux, uy, uz;
  assign ux = m_tdata[15:0];
  assign uy = m_tdata[31:16];
  assign uz = m_tdata[47:32];

  // No output beat right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A waiting output beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output beat changed");

  // When the output side can move, the whole pipeline can move and input is taken.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input not ready while output side is free");

  // Every component of a unit vector stays within plus or minus one.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (ux <= UnitMax && ux >= -UnitMax && uy <= UnitMax && uy >= -UnitMax &&
                  uz <= UnitMax && uz >= -UnitMax))
    else $error("unit component out of range");

endmodule

bind normal_map_texel_decode_core nmtd_checker u_nmtd_checker (.*);

>>> bench/tb.sv
// Self-checking testbench for the normal-map texel decoder with exact Q1.14 prediction.
`timescale 1ns / 100ps

module tb;

  import nmtd_pkg::*;

  localparam int unsigned UnitOne = 1 << FracBits;

  // Input beat layout: the red byte sits in the lowest bits, so it is the last struct member.
  typedef struct packed {
    logic [CodeW-1:0] blue_code;
    logic [CodeW-1:0] green_code;
    logic [CodeW-1:0] red_code;
  } texel_t;

  // Output beat layout: unit_x in bits [15:0], unit_z in bits [47:32].
  typedef struct packed {
    logic signed [UnitW-1:0] unit_z;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_x;
  } unit_normal_t;

  // Holds the unit normals still owed by the block, oldest first, and checks each output beat.
  class normal_scoreboard;
    unit_normal_t owed_normals[$];
    int           mismatches = 0;

    // Exact round-half-away-from-zero of 16384*a/sqrt(sum_sq). The magnitude is the
    // largest k with (2k-1)^2 * sum_sq <= 2^30 * a^2, found one bit at a time.
    function automatic logic [UnitW-1:0] scaled_component(int signed a,
                                                          longint unsigned sum_sq);
      longint unsigned mag;
      longint unsigned bound;
      longint unsigned odd;
      int unsigned     q;
      int unsigned     k;
      mag   = (a < 0) ? longint'(-a) : longint'(a);
      bound = (mag * mag) << (2 * FracBits + 2);
      q     = 0;
      for (int unsigned b = UnitOne; b != 0; b >>= 1) begin
        k = q | b;
        if (k <= UnitOne) begin
          odd = 2 * k - 1;
          if (odd * odd * sum_sq <= bound) q = k;
        end
      end
      return (a < 0) ? UnitW'(0 - q) : UnitW'(q);
    endfunction

    // An accepted texel: work out its unit normal and queue it.
    function void note_texel(texel_t t);
      int signed       a [3];
      longint unsigned sum_sq;
      logic [UnitW-1:0] comp [3];
      unit_normal_t    n;
      // Each code c stands for the odd integer 2c-255 over a denominator of 255.
      a[0] = 2 * int'(t.red_code) - 255;
      a[1] = 2 * int'(t.green_code) - 255;
      a[2] = 2 * int'(t.blue_code) - 255;
      sum_sq = 0;
      for (int i = 0; i < 3; i++) sum_sq += longint'(a[i] * a[i]);
      for (int i = 0; i < 3; i++) comp[i] = scaled_component(a[i], sum_sq);
      n.unit_x = comp[0];
      n.unit_y = comp[1];
      n.unit_z = comp[2];
      owed_normals.push_back(n);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    // An accepted output beat: compare it field by field with the oldest owed normal.
    task check_normal(unit_normal_t got);
      unit_normal_t want;
      if (owed_normals.size() == 0) begin
        report_mismatch("unexpected output beat, unit_x", got.unit_x, 0);
        return;
      end
      want = owed_normals.pop_front();
      if (got.unit_x !== want.unit_x) report_mismatch("unit_x", got.unit_x, want.unit_x);
      if (got.unit_y !== want.unit_y) report_mismatch("unit_y", got.unit_y, want.unit_y);
      if (got.unit_z !== want.unit_z) report_mismatch("unit_z", got.unit_z, want.unit_z);
    endtask

    function int owed_count();
      return owed_normals.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // red_code [7:0], green_code [15:8], blue_code [23:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // unit_x [15:0], unit_y [31:16], unit_z [47:32]

  // Idle rates in percent for each side, and a long receiver hold-off requested by the
  // stimulus and counted down by the receiver process.
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 87;
  int unsigned hold_off_cycles = 0;

  normal_scoreboard normals = new();

  normal_map_texel_decode_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Generous ceiling: the slowest correct run needs well under a tenth of this.
  initial begin
    #1_000_000;
    $display("[normal_map_texel_decode_core] ERROR");
    $finish;
  end

  // Receiver side: ready changes at the falling edge, either held low for a requested
  // stretch or dropped at random at the current idle rate.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Output beats are taken at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) normals.check_normal(unit_normal_t'(m_tdata));
  end

  // Offers one texel, called at a falling edge and returning at a falling edge. Random idle
  // cycles come first, so that valid stays high between back-to-back beats.
  task automatic send_texel(texel_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    normals.note_texel(t);
    @(negedge clk);
  endtask

  task automatic send_codes(int r, int g, int b);
    texel_t t;
    t.red_code   = CodeW'(r);
    t.green_code = CodeW'(g);
    t.blue_code  = CodeW'(b);
    send_texel(t);
  endtask

  // Random texels with a mix of shapes: fully random bytes, typical tangent-space normals
  // (z pointing out), codes around the midpoint where components are tiny, and codes at
  // the ends and the middle of the range.
  task automatic send_random_texels(int count);
    texel_t      t;
    int unsigned shape;
    for (int i = 0; i < count; i++) begin
      shape = $urandom_range(0, 9);
      if (shape < 5) begin
        t = texel_t'(24'($urandom));
      end else if (shape < 8) begin
        t.red_code   = CodeW'($urandom_range(64, 191));
        t.green_code = CodeW'($urandom_range(64, 191));
        t.blue_code  = CodeW'($urandom_range(192, 255));
      end else if (shape == 8) begin
        t.red_code   = CodeW'($urandom_range(120, 135));
        t.green_code = CodeW'($urandom_range(120, 135));
        t.blue_code  = CodeW'($urandom_range(120, 135));
      end else begin
        for (int c = 0; c < 3; c++) begin
          case ($urandom_range(0, 5))
            0: t[c*CodeW +: CodeW] = 8'd0;
            1: t[c*CodeW +: CodeW] = 8'd1;
            2: t[c*CodeW +: CodeW] = 8'd127;
            3: t[c*CodeW +: CodeW] = 8'd128;
            4: t[c*CodeW +: CodeW] = 8'd254;
            default: t[c*CodeW +: CodeW] = 8'd255;
          endcase
        end
      end
      send_texel(t);
    end
  endtask

  // Stops offering beats until every owed normal has come out.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (normals.owed_count() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed texels. All codes at 0 or 255 give equal components of full size; 127 and
    // 128 give the smallest odd components (-1 and +1); one strong axis with the others
    // near the midpoint drives one output close to the full-scale value 16384.
    send_codes(0, 0, 0);
    send_codes(255, 255, 255);
    send_codes(128, 128, 128);
    send_codes(127, 127, 127);
    send_codes(255, 128, 128);
    send_codes(0, 127, 127);
    send_codes(128, 255, 127);
    send_codes(127, 0, 128);
    send_codes(128, 128, 255);
    send_codes(127, 127, 0);
    send_codes(0, 255, 0);
    send_codes(255, 0, 255);
    send_codes(255, 0, 128);
    send_codes(1, 254, 128);
    send_codes(128, 128, 200);
    send_codes(170, 85, 240);

    // Sender idles often, receiver far more.
    send_random_texels(560);
    wait_for_drain();

    // Roles swapped.
    send_idle_pct = 87;
    recv_idle_pct = 38;
    send_random_texels(560);
    wait_for_drain();

    // No idling. The receiver first holds off long enough for the pipeline to fill
    // while the sender keeps offering beats, so the input has to stall.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 300;
    send_random_texels(100);
    wait_for_drain();
    send_random_texels(460);
    s_tvalid <= 1'b0;

    while (normals.owed_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (normals.owed_count() != 0) normals.report_mismatch("normals never delivered",
                                                           normals.owed_count(), 0);
    if (normals.mismatches == 0) begin
      $display("[normal_map_texel_decode_core] OK");
    end else begin
      $display("[normal_map_texel_decode_core] ERROR");
    end
    $finish;
  end

endmodule
